// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication form: antecedent holds -> consequent holds on the same edge
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/mls_pkg.sv =====
// ----------------------------------------------------------------------------
// mls_pkg
// types, constants and helpers of the lane scheduler
// ----------------------------------------------------------------------------
package mls_pkg;

    localparam int LANES       = 8;
    localparam int LANE_W      = $clog2(LANES);
    localparam int NIB_W       = 4;
    localparam int STACK_W     = (LANES + 1) * NIB_W;
    localparam int TAG_W       = 16;
    localparam int LEN_W       = 20;
    localparam int BLK_W       = 16;
    localparam int KS_W        = 2;
    localparam int KIND_W      = 2;
    localparam int BLOCK_SHIFT = 4;    // 16-byte blocks

    localparam logic [BLK_W-1:0] EMPTY_MARK = 16'hFFFF;
    localparam logic [BLK_W-1:0] MAX_BLOCKS = 16'hFFFE;
    localparam logic [NIB_W-1:0] STACK_MARK = 4'hF;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

    typedef enum logic [KIND_W-1:0] {
        KIND_QUEUED = 2'd0,
        KIND_RUN    = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUEUED,
        S_MIN,
        S_SUB,
        S_RUN,
        S_DONE
    } t_eng_state;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [BLK_W-1:0] blocks;
    } t_cmd;

    typedef struct packed {
        t_kind             kind;
        logic [LANE_W-1:0] lane;
        logic [TAG_W-1:0]  tag;
        logic [BLK_W-1:0]  blocks;
        logic [KS_W-1:0]   key_size;
        logic              last;
    } t_result;

    // lanes 0..LANES-1 from the top, marker at the bottom
    function automatic logic [STACK_W-1:0] stack_reset();
        logic [STACK_W-1:0] s;
        s = STACK_W'(STACK_MARK);
        for (int i = LANES - 1; i >= 0; i--) begin
            s = {s[STACK_W-NIB_W-1:0], NIB_W'(i)};
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/mls_front.sv =====
// ----------------------------------------------------------------------------
// mls_front
// takes submissions, converts bytes to saturated blocks, queues commands
// ----------------------------------------------------------------------------
module mls_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mls_pkg::TAG_W-1:0]   i_job_tag,
    input  logic [mls_pkg::LEN_W-1:0]   i_len_bytes,
    output logic                        o_cmd_valid,
    output mls_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_pop
);
    import mls_pkg::*;

    t_cmd                r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr, n_wr;
    logic [CQ_PTR_W-1:0] r_rd, n_rd;
    logic [CQ_PTR_W:0]   r_cnt, n_cnt;
    logic                wr_en, rd_en;
    logic [BLK_W-1:0]    blk_raw;
    t_cmd                cmd_in;

    assign blk_raw = i_len_bytes[LEN_W-1:BLOCK_SHIFT];

    always_comb begin
        cmd_in.tag    = i_job_tag;
        cmd_in.blocks = (blk_raw > MAX_BLOCKS) ? MAX_BLOCKS : blk_raw;
    end

    assign full        = (r_cnt == (CQ_PTR_W+1)'(CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    assign wr_en       = push && !full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr  = wr_en ? r_wr + 1'b1 : r_wr;
        n_rd  = rd_en ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/mls_engine.sv =====
// ----------------------------------------------------------------------------
// mls_engine
// lane state, free stack, min search, run issue and completion scan
// ----------------------------------------------------------------------------
module mls_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mls_pkg::KS_W-1:0]    i_cfg_wdata,
    input  logic                        i_cmd_valid,
    input  mls_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_res_push,
    output mls_pkg::t_result            o_res,
    input  logic                        i_res_full
);
    import mls_pkg::*;

    t_eng_state          r_state, n_state;
    logic [LANE_W-1:0]   r_idx;
    logic [STACK_W-1:0]  r_stack;
    logic [BLK_W-1:0]    r_rem [LANES];
    logic [TAG_W-1:0]    r_tag [LANES];
    logic [BLK_W-1:0]    r_min;
    logic [LANES-1:0]    r_zmask;
    logic [KS_W-1:0]     r_ks;
    logic [LANE_W-1:0]   r_res_lane;
    logic [TAG_W-1:0]    r_res_tag;

    logic [NIB_W-1:0]    top_nib;
    logic [LANE_W-1:0]   top_lane;
    logic                lane_ok;
    logic [STACK_W-1:0]  stack_pop;
    logic                fills_last;
    logic                idx_end;
    logic                cur_zero;
    logic [LANES-1:0]    zm_shift;
    logic                higher_zero;
    logic                scan_step;

    assign top_nib    = r_stack[NIB_W-1:0];
    assign top_lane   = top_nib[LANE_W-1:0];
    assign lane_ok    = (top_nib < NIB_W'(LANES));
    assign stack_pop  = r_stack >> NIB_W;
    assign fills_last = (stack_pop == STACK_W'(STACK_MARK));
    assign idx_end    = (r_idx == LANE_W'(LANES - 1));
    assign cur_zero   = r_zmask[r_idx];
    assign zm_shift   = r_zmask >> r_idx;
    assign higher_zero = |zm_shift[LANES-1:1];
    assign scan_step  = !cur_zero || !i_res_full;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && lane_ok) begin
                    n_state = fills_last ? S_MIN : S_QUEUED;
                end
            end
            S_QUEUED: begin
                if (!i_res_full) n_state = S_IDLE;
            end
            S_MIN: begin
                if (idx_end) n_state = S_SUB;
            end
            S_SUB: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (!i_res_full) n_state = S_DONE;
            end
            S_DONE: begin
                if (scan_step && idx_end) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            S_QUEUED: begin
                o_res_push  = !i_res_full;
                o_res.kind  = KIND_QUEUED;
                o_res.lane  = r_res_lane;
                o_res.tag   = r_res_tag;
                o_res.last  = 1'b1;
            end
            S_RUN: begin
                o_res_push     = !i_res_full;
                o_res.kind     = KIND_RUN;
                o_res.blocks   = r_min;
                o_res.key_size = r_ks;
                o_res.last     = (r_zmask == '0);
            end
            S_DONE: begin
                o_res_push = cur_zero && !i_res_full;
                o_res.kind = KIND_DONE;
                o_res.lane = r_idx;
                o_res.tag  = r_tag[r_idx];
                o_res.last = !higher_zero;
            end
            S_MIN, S_SUB: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_stack <= stack_reset();
            r_ks    <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_rem[i] <= EMPTY_MARK;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_ks <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_cmd_valid && lane_ok) begin
                        r_rem[top_lane] <= i_cmd.blocks;
                        r_stack         <= stack_pop;
                    end
                end
                S_MIN: begin
                    r_idx <= idx_end ? '0 : r_idx + 1'b1;
                end
                S_SUB: begin
                    for (int i = 0; i < LANES; i++) begin
                        r_rem[i] <= r_rem[i] - r_min;
                    end
                end
                S_DONE: begin
                    if (scan_step) begin
                        r_idx <= idx_end ? '0 : r_idx + 1'b1;
                        if (cur_zero) begin
                            r_rem[r_idx] <= EMPTY_MARK;
                            r_stack <= {r_stack[STACK_W-NIB_W-1:0], NIB_W'(r_idx)};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_min <= EMPTY_MARK;
                if (i_cmd_valid && lane_ok) begin
                    r_tag[top_lane] <= i_cmd.tag;
                    r_res_lane      <= top_lane;
                    r_res_tag       <= i_cmd.tag;
                end
            end
            S_MIN: begin
                if (r_rem[r_idx] < r_min) r_min <= r_rem[r_idx];
            end
            S_SUB: begin
                for (int i = 0; i < LANES; i++) begin
                    r_zmask[i] <= (r_rem[i] == r_min);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/mls_res_queue.sv =====
// ----------------------------------------------------------------------------
// mls_res_queue
// result queue towards the consumer
// ----------------------------------------------------------------------------
module mls_res_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mls_pkg::t_result    i_res,
    output logic                o_full,
    output logic                empty,
    input  logic                pop,
    output mls_pkg::t_result    o_res
);
    import mls_pkg::*;

    t_result             r_q [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wr;
    logic [RQ_PTR_W-1:0] r_rd;
    logic [RQ_PTR_W:0]   r_cnt, n_cnt;
    logic                wr_en, rd_en;

    assign o_full = (r_cnt == (RQ_PTR_W+1)'(RQ_DEPTH));
    assign empty  = (r_cnt == '0);
    assign o_res  = r_q[r_rd];
    assign wr_en  = i_push && !o_full;
    assign rd_en  = pop && !empty;

    always_comb begin
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= i_res;
        end
    end

endmodule

// ===== rtl/core/multibuffer_lane_scheduler.sv =====
// ----------------------------------------------------------------------------
// multibuffer_lane_scheduler
// job scheduler for an eight-lane multi-buffer cipher engine
// ----------------------------------------------------------------------------
// submissions enter through push/full, one transaction per job (tag, bytes)
// results leave through empty/pop: queued, run and completed transactions
// key size is written through i_cfg_we/i_cfg_wdata; the user writes it
// only while the block is idle, the block itself does not enforce it
// a job that leaves a free lane gives one queued result, written to the
// result queue from S_QUEUED once the engine has popped the job
// the job that takes the last lane starts a min search over the lanes, one
// lane a cycle, then a subtract step, the run result and a completion
// scan of one lane a cycle, held at a finished lane when the queue is full
// the front queue holds two jobs, so submissions keep being taken while
// the engine works or results wait; the result queue holds four results
// and the engine stalls in place when it must push a result and it is full
// reset (synchronous, active low) frees every lane, marks every lane empty
// and sets the 2-bit key size code to 0; both queues empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multibuffer_lane_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [mls_pkg::KS_W-1:0]     i_cfg_wdata,
    // submissions
    input  logic                         push,
    output logic                         full,
    input  logic [mls_pkg::TAG_W-1:0]    i_job_tag,
    input  logic [mls_pkg::LEN_W-1:0]    i_len_bytes,
    // results
    output logic                         empty,
    input  logic                         pop,
    output logic [mls_pkg::KIND_W-1:0]   o_kind,
    output logic [mls_pkg::LANE_W-1:0]   o_lane,
    output logic [mls_pkg::TAG_W-1:0]    o_job_tag_res,
    output logic [mls_pkg::BLK_W-1:0]    o_blocks,
    output logic [mls_pkg::KS_W-1:0]     o_run_key_size,
    output logic                         o_last
);
    import mls_pkg::*;

    // front to engine command link
    logic    cmd_valid;
    logic    cmd_pop;
    t_cmd    cmd;

    // engine to result queue link
    logic    res_push;
    logic    res_full;
    t_result res_in;
    t_result res_out;

    // result kinds as seen by the consumer
    logic    out_run;
    logic    out_queued;

    // accept and classify: bytes to saturated block count
    mls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_job_tag   (i_job_tag),
        .i_len_bytes (i_len_bytes),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // lane bookkeeping and result generation
    mls_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    // results wait here for the consumer
    mls_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    assign o_kind         = res_out.kind;
    assign o_lane         = res_out.lane;
    assign o_job_tag_res  = res_out.tag;
    assign o_blocks       = res_out.blocks;
    assign o_run_key_size = res_out.key_size;
    assign o_last         = res_out.last;

    assign out_run    = !empty && (o_kind == KIND_RUN);
    assign out_queued = !empty && (o_kind == KIND_QUEUED);

    // only the three defined result kinds ever reach the consumer
    `ASSERT_IMPL(a_kind_defined, !empty, o_kind <= KIND_DONE, "undefined result kind")

    // a run result carries no lane and no tag
    `ASSERT_IMPL(a_run_clean, out_run, {o_lane, o_job_tag_res} == '0, "run with lane or tag")

    // a queued job is always the only result of its submission
    `ASSERT_IMPL(a_queued_last, out_queued, o_last, "queued result without last")

    // the engine never pushes into a full result queue
    `ASSERT_IMPL(a_no_overflow, res_push, !res_full, "push into full result queue")

endmodule

// ===== tb/multibuffer_lane_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multibuffer_lane_scheduler_test
// self-checking bench for the eight-lane job scheduler
// ----------------------------------------------------------------------------
// jobs go in through push/full and results come out through empty/pop, both
// sides idling at random. a software copy of the lane bookkeeping works out
// the queued, run and completed transactions for every accepted job, and each
// popped result is matched against the oldest of them. a short table of
// hand-picked jobs comes first, then randomised phases, each at a key size
// set before it, with one long consumer stall that backs the block up to full
// ----------------------------------------------------------------------------
module multibuffer_lane_scheduler_test;
    import mls_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_WAIT      = 18;
    localparam int SETTLE_CYCLES = 40;     // engine scan drains well inside this
    localparam int HOLD_CYCLES   = 300;    // long consumer stall
    localparam int WATCHDOG      = 2000;   // quiet cycles before giving up
    localparam int PHASES        = 6;
    localparam int PHASE_JOBS    = 70;
    localparam int DIR_ROWS      = 20;
    localparam int REPORT_MAX    = 10;
    localparam int NO_WRITE      = -1;

    // one row of the directed table; exp only means something when typed is set
    typedef struct {
        int              ks;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        bit              typed;
        t_result         exp;
    } t_job_row;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [KS_W-1:0]     cfg_wdata   = '0;
    logic                push        = 1'b0;
    logic                full;
    logic [TAG_W-1:0]    job_tag     = '0;
    logic [LEN_W-1:0]    len_bytes   = '0;
    logic                empty;
    logic                pop         = 1'b0;
    logic [KIND_W-1:0]   o_kind;
    logic [LANE_W-1:0]   o_lane;
    logic [TAG_W-1:0]    o_job_tag_res;
    logic [BLK_W-1:0]    o_blocks;
    logic [KS_W-1:0]     o_run_key_size;
    logic                o_last;

    // shadow copy of the scheduler state
    logic [STACK_W-1:0]  lane_stack;
    logic [BLK_W-1:0]    blocks_left [LANES];
    logic [TAG_W-1:0]    lane_owner  [LANES];
    logic [KS_W-1:0]     key_size_now;

    t_result             due_results [$];   // results still owed by the block

    int  fault_cnt    = 0;
    int  result_cnt   = 0;
    int  jobs_sent    = 0;
    int  runs_seen    = 0;
    int  done_seen    = 0;
    int  widest_batch = 0;
    int  full_stalls  = 0;
    int  quiet_cycles = 0;
    bit  send_calm    = 1'b0;
    bit  recv_calm    = 1'b0;
    bit  squeeze_req  = 1'b0;
    bit  squeeze_done = 1'b0;

    // directed jobs: first fill every lane from reset with saturating lengths
    // (all 65534 blocks, so one run frees all eight), then zero-length and short
    // jobs under the unused key size, then a few under the other sizes
    t_job_row dir_rows [DIR_ROWS] = '{
        '{0,        16'h0000, 20'd1048559, 1'b1, '{KIND_QUEUED, 3'd0, 16'h0000, '0, '0, 1'b1}},
        '{NO_WRITE, 16'hFFFF, 20'hFFFFF,   1'b1, '{KIND_QUEUED, 3'd1, 16'hFFFF, '0, '0, 1'b1}},
        '{NO_WRITE, 16'h8000, 20'd1048560, 1'b1, '{KIND_QUEUED, 3'd2, 16'h8000, '0, '0, 1'b1}},
        '{NO_WRITE, 16'h0001, 20'd1048565, 1'b1, '{KIND_QUEUED, 3'd3, 16'h0001, '0, '0, 1'b1}},
        '{NO_WRITE, 16'h7FFF, 20'd1048570, 1'b1, '{KIND_QUEUED, 3'd4, 16'h7FFF, '0, '0, 1'b1}},
        '{NO_WRITE, 16'h1234, 20'd1048575, 1'b1, '{KIND_QUEUED, 3'd5, 16'h1234, '0, '0, 1'b1}},
        '{NO_WRITE, 16'hC0DE, 20'd1048568, 1'b1, '{KIND_QUEUED, 3'd6, 16'hC0DE, '0, '0, 1'b1}},
        '{NO_WRITE, 16'h0BAD, 20'd1048561, 1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{3,        16'h5555, 20'd0,       1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'hAAAA, 20'd15,      1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'h0F0F, 20'd16,      1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'hF0F0, 20'd31,      1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'h3C3C, 20'd4095,    1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'hC3C3, 20'd32,      1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'h6666, 20'd48,      1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'h9999, 20'd0,       1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{2,        16'h1357, 20'd256,     1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'h2468, 20'd64,      1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{NO_WRITE, 16'hACE0, 20'd0,       1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}},
        '{1,        16'hBDF1, 20'd1024,    1'b0, '{KIND_QUEUED, '0, '0, '0, '0, '0}}
    };

    int phase_keys [PHASES] = '{2, 3, 0, 1, 3, 2};

    multibuffer_lane_scheduler DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .push           (push),
        .full           (full),
        .i_job_tag      (job_tag),
        .i_len_bytes    (len_bytes),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_lane         (o_lane),
        .o_job_tag_res  (o_job_tag_res),
        .o_blocks       (o_blocks),
        .o_run_key_size (o_run_key_size),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // bookkeeping after reset: lanes 0..7 on the stack, lane 0 on top
    task automatic clear_lanes();
        lane_stack = STACK_W'(STACK_MARK);
        for (int i = LANES - 1; i >= 0; i--) begin
            lane_stack = {lane_stack[STACK_W-NIB_W-1:0], NIB_W'(i)};
        end
        for (int i = 0; i < LANES; i++) begin
            blocks_left[i] = EMPTY_MARK;
            lane_owner[i]  = '0;
        end
        key_size_now = '0;
    endtask

    // works out what one accepted job causes; queues it unless the caller
    // has typed the expectation in by hand
    task automatic schedule_job(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len,
                                input bit keep);
        logic [NIB_W-1:0] lane;
        logic [LEN_W-1:0] blk;
        logic [BLK_W-1:0] least;
        t_result          batch [$];
        int               freed;
        lane  = lane_stack[NIB_W-1:0];
        freed = 0;
        // a popped nibble that is no lane drops the job (never from reset)
        if (lane >= LANES) return;
        lane_stack = lane_stack >> NIB_W;
        blk = len >> BLOCK_SHIFT;
        if (blk > LEN_W'(MAX_BLOCKS)) blk = LEN_W'(MAX_BLOCKS);   // long job saturates
        lane_owner[lane]  = tag;
        blocks_left[lane] = blk[BLK_W-1:0];
        if (lane_stack != STACK_W'(STACK_MARK)) begin
            batch.push_back('{KIND_QUEUED, lane[LANE_W-1:0], tag, '0, '0, 1'b1});
        end else begin
            // last lane taken: advance every lane by the shortest one
            least = blocks_left[0];
            for (int i = 1; i < LANES; i++) begin
                if (blocks_left[i] < least) least = blocks_left[i];
            end
            for (int i = 0; i < LANES; i++) begin
                blocks_left[i] = blocks_left[i] - least;
            end
            batch.push_back('{KIND_RUN, '0, '0, least, key_size_now, 1'b0});
            runs_seen++;
            // completions in ascending lane order, each lane back on the stack
            for (int i = 0; i < LANES; i++) begin
                if (blocks_left[i] == '0) begin
                    batch.push_back('{KIND_DONE, LANE_W'(i), lane_owner[i], '0, '0, 1'b0});
                    blocks_left[i] = EMPTY_MARK;
                    lane_stack = {lane_stack[STACK_W-NIB_W-1:0], NIB_W'(i)};
                    freed++;
                end
            end
            batch[batch.size()-1].last = 1'b1;
            done_seen += freed;
            if (freed > widest_batch) widest_batch = freed;
        end
        if (keep) begin
            foreach (batch[k]) due_results.push_back(batch[k]);
        end
    endtask

    // offers one job after a random gap and waits for the handshake
    task automatic submit(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len,
                          input bit typed, input t_result want);
        int gap;
        if ($urandom_range(0, 23) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        job_tag   <= tag;
        len_bytes <= len;
        push      <= 1'b1;
        do @(posedge i_clk); while (full);
        schedule_job(tag, len, !typed);
        if (typed) due_results.push_back(want);
        jobs_sent++;
    endtask

    // key size only changes once every owed result is out and the scan is done
    task automatic set_key_size(input int ks);
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= KS_W'(ks);
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        key_size_now = KS_W'(ks);
    endtask

    // mostly short jobs so lanes tie and complete together, some long ones
    // that sit in their lanes, and a few that saturate
    function automatic logic [LEN_W-1:0] draw_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) return LEN_W'(($urandom_range(0, 5) << 4) | $urandom_range(0, 15));
        if (pick < 60) return LEN_W'($urandom_range(0, 2047));
        if (pick < 72) return LEN_W'($urandom_range(0, 20'hFFFFF));
        if (pick < 82) return LEN_W'($urandom_range(1048528, 20'hFFFFF));
        return LEN_W'($urandom_range(1, 4) * 64);
    endfunction

    task automatic log_fault(input string what, input t_result want, input t_result got);
        fault_cnt++;
        if (fault_cnt <= REPORT_MAX) begin
            $display("%0t %s: want kind=%0d lane=%0d tag=%h blocks=%0d ks=%0d last=%0b",
                     $realtime, what, want.kind, want.lane, want.tag, want.blocks,
                     want.key_size, want.last);
            $display("%0t %s:  got kind=%0d lane=%0d tag=%h blocks=%0d ks=%0d last=%0b",
                     $realtime, what, got.kind, got.lane, got.tag, got.blocks,
                     got.key_size, got.last);
        end
    endtask

    // result side: random stall per transaction, one long stall on request
    initial begin : result_sink
        int      stall;
        t_result got;
        t_result want;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 23) == 0) recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = '{t_kind'(o_kind), o_lane, o_job_tag_res, o_blocks, o_run_key_size, o_last};
            result_cnt++;
            if (due_results.size() == 0) begin
                log_fault("unexpected result", '{KIND_QUEUED, '0, '0, '0, '0, '0}, got);
            end else begin
                want = due_results.pop_front();
                if (got !== want) log_fault("mismatch", want, got);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (push && full) full_stalls <= full_stalls + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("timeout after %0d quiet cycles, %0d results owed",
                     quiet_cycles, due_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : job_source
        t_result none;
        none = '{KIND_QUEUED, '0, '0, '0, '0, '0};
        clear_lanes();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].ks != NO_WRITE) set_key_size(dir_rows[r].ks);
            submit(dir_rows[r].tag, dir_rows[r].len, dir_rows[r].typed, dir_rows[r].exp);
        end

        // random phases, key size changed between them
        for (int p = 0; p < PHASES; p++) begin
            set_key_size(phase_keys[p]);
            for (int n = 0; n < PHASE_JOBS; n++) begin
                // long consumer stall early in the second phase, jobs keep coming
                if (p == 1 && n == 10) squeeze_req = 1'b1;
                submit(TAG_W'($urandom_range(0, 16'hFFFF)), draw_len(), 1'b0, none);
            end
        end

        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d jobs submitted, %0d results checked, %0d mismatches",
                 jobs_sent, result_cnt, fault_cnt);
        $display("%0d runs, %0d lanes completed, up to %0d at once, %0d cycles held off",
                 runs_seen, done_seen, widest_batch, full_stalls);
        if (fault_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
